@@ rtl/prcd_pkg.sv @@
// ----------------------------------------------------------------------------
// prcd_pkg: shared types, constants and lookup functions
// Holds the per-color front-end decode, the hue and saturation curves and
// the widths used by the color difference pipeline.
// ----------------------------------------------------------------------------
package prcd_pkg;

   localparam int unsigned QUOT_WIDTH = 6;
   localparam int unsigned NUM_WIDTH  = 14;

   // Sector offsets and sector scale factors.
   localparam logic [7:0] OFF_RED_YEL  = 8'h00;
   localparam logic [7:0] OFF_YEL_GRN  = 8'h35;
   localparam logic [7:0] OFF_GRN_CYN  = 8'h6A;
   localparam logic [7:0] OFF_CYN_BLU  = 8'h80;
   localparam logic [7:0] OFF_BLU_MAG  = 8'hB5;
   localparam logic [7:0] OFF_MAG_RED  = 8'hEA;
   localparam logic [5:0] SCALE_WIDE   = 6'h35;
   localparam logic [5:0] SCALE_NARROW = 6'h16;

   // Luma weights.
   localparam logic [6:0] LUMA_RED   = 7'd98;
   localparam logic [7:0] LUMA_GREEN = 8'd128;
   localparam logic [4:0] LUMA_BLUE  = 5'd30;

   // Weight register reset values and indexes.
   localparam logic [8:0] HUE_WEIGHT_RESET = 9'h120;
   localparam logic [8:0] SAT_WEIGHT_RESET = 9'h050;
   localparam logic [8:0] LUM_WEIGHT_RESET = 9'h180;
   localparam logic [1:0] REG_HUE_WEIGHT   = 2'd0;
   localparam logic [1:0] REG_SAT_WEIGHT   = 2'd1;
   localparam logic [1:0] REG_LUM_WEIGHT   = 2'd2;

   // Result of the per-color sector decode that feeds the divider.
   typedef struct packed {
      logic [NUM_WIDTH-1:0] num;
      logic [7:0]           den;
      logic [7:0]           offset;
      logic                 grey;
   } front_type;

   function automatic front_type color_front(input logic [23:0] c);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] x;
      logic [5:0] m;
      front_type  f;
      r = c[23:16];
      g = c[15:8];
      b = c[7:0];
      f.grey = 1'b0;
      if (r > g) begin
         if (g > b) begin
            f.den = r - b; x = g - b; m = SCALE_WIDE; f.offset = OFF_RED_YEL;
         end else if (b > r) begin
            f.den = b - g; x = r - g; m = SCALE_WIDE; f.offset = OFF_BLU_MAG;
         end else begin
            f.den = r - g; x = r - b; m = SCALE_NARROW; f.offset = OFF_MAG_RED;
         end
      end else begin
         if (b > g) begin
            f.den = b - r; x = b - g; m = SCALE_WIDE; f.offset = OFF_CYN_BLU;
         end else if (r > b) begin
            f.den = g - b; x = g - r; m = SCALE_WIDE; f.offset = OFF_YEL_GRN;
         end else begin
            f.den = g - r; x = b - r; m = SCALE_NARROW; f.offset = OFF_GRN_CYN;
            f.grey = (f.den == 8'd0);
         end
      end
      f.num = {6'b000000, x} * {8'h00, m};
      return f;
   endfunction

   // Piecewise-linear hue remap; every segment has unit slope, so each
   // entry is the input shifted by a segment offset, modulo 256.
   function automatic logic [7:0] hue_curve(input logic [7:0] i);
      logic [7:0] v;
      if (i < 8'h15)      v = i;
      else if (i < 8'h35) v = i - 8'h15 + 8'h10;
      else if (i < 8'h55) v = i;
      else if (i < 8'h6A) v = i - 8'h55 + 8'h5A;
      else if (i < 8'h75) v = i;
      else if (i < 8'h80) v = i - 8'h75 + 8'h72;
      else if (i < 8'hA5) v = i;
      else if (i < 8'hB5) v = i - 8'hA5 + 8'hAA;
      else if (i < 8'hC5) v = i;
      else if (i < 8'hEA) v = i - 8'hC5 + 8'hC0;
      else if (i < 8'hF5) v = i;
      else                v = i + 8'h03;
      return v;
   endfunction

   // Piecewise-linear saturation remap.
   function automatic logic [7:0] sat_curve(input logic [7:0] i);
      logic [9:0] t;
      logic [7:0] v;
      if (i < 8'h55) begin
         t = {2'b00, i} * 10'd3;
         v = t[8:1];
      end else if (i < 8'h96) begin
         t = {2'b00, i - 8'h55} * 10'd5;
         v = 8'h7F + t[9:2];
      end else if (i < 8'hB6) begin
         v = 8'hD0 + (i - 8'h96);
      end else if (i < 8'hC6) begin
         v = 8'hF0 + ((i - 8'hB6) >> 1);
      end else if (i < 8'hF6) begin
         v = 8'hF8 + ((i - 8'hC6) >> 3);
      end else begin
         v = 8'hFF;
      end
      return v;
   endfunction

endpackage

@@ rtl/perceptual_rgb_color_difference.sv @@
// ----------------------------------------------------------------------------
// perceptual_rgb_color_difference: perceptual distance of two RGB colors
// Throughput is one color pair per cycle while no response stall holds it;
// the six-stage sector divider, the curve and distance stages, the two
// multiplier stages and the summing stage make up the pipeline.
// A response stall holds the whole pipeline in place.
// Reset clears all valid bits and loads the default weights.
// ----------------------------------------------------------------------------
module perceptual_rgb_color_difference
   import prcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // color_a [23:0], color_b [47:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // difference [12:0], zero pad [15:13]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata
);

   localparam int unsigned STAGES  = 11;
   localparam int unsigned DIV_OUT = QUOT_WIDTH;

   logic              stage_en;
   logic [STAGES-1:0] valid_ff;
   logic [8:0]        hue_w_ff, sat_w_ff, lum_w_ff;

   front_type  front_a, front_b;
   logic [15:0] luma_a, luma_b, luma_diff;
   logic [QUOT_WIDTH-1:0] quot_a, quot_b;

   logic [7:0]  off_a_ff  [DIV_OUT+1];
   logic [7:0]  off_b_ff  [DIV_OUT+1];
   logic        grey_a_ff [DIV_OUT+1];
   logic        grey_b_ff [DIV_OUT+1];
   logic [15:0] luma_ff   [8];
   logic        same_ff   [10];
   logic [7:0]  den_a_ff  [DIV_OUT];
   logic [7:0]  den_b_ff  [DIV_OUT];

   logic [7:0]  hue_a_ff, hue_b_ff, sat_a_ff, sat_b_ff;
   logic [7:0]  raw_a, raw_b;
   logic [7:0]  hmin_ff, smin_ff, sdiff_ff, hmin_in, smin_in, sdiff_in;
   logic [15:0] hprod_ff;
   logic [16:0] sat_term_ff, sat_term2_ff, lum_term_ff, lum_term2_ff;
   logic [24:0] lum_prod;
   logic [24:0] hue_prod;
   logic [17:0] hue_term_ff;
   logic [19:0] sum;
   logic [12:0] diff_ff;

   // The pipeline advances whenever the output slot is empty or taken.
   assign stage_en   = !valid_ff[STAGES-1] || rsp_tready;
   assign req_tready = stage_en;
   assign rsp_tvalid = valid_ff[STAGES-1];
   assign rsp_tdata  = {3'b000, diff_ff};

   // Weight registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hue_w_ff <= HUE_WEIGHT_RESET;
         sat_w_ff <= SAT_WEIGHT_RESET;
         lum_w_ff <= LUM_WEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_HUE_WEIGHT: hue_w_ff <= csr_wdata;
            REG_SAT_WEIGHT: sat_w_ff <= csr_wdata;
            REG_LUM_WEIGHT: lum_w_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (stage_en) begin
         valid_ff <= {valid_ff[STAGES-2:0], req_tvalid};
      end
   end

   // Front end: sector decode and luma difference.
   assign front_a   = color_front(req_tdata[23:0]);
   assign front_b   = color_front(req_tdata[47:24]);
   assign luma_a    = {8'h00, req_tdata[23:16]} * {9'h000, LUMA_RED}
                    + {8'h00, req_tdata[15:8]} * {8'h00, LUMA_GREEN}
                    + {8'h00, req_tdata[7:0]} * {11'h000, LUMA_BLUE};
   assign luma_b    = {8'h00, req_tdata[47:40]} * {9'h000, LUMA_RED}
                    + {8'h00, req_tdata[39:32]} * {8'h00, LUMA_GREEN}
                    + {8'h00, req_tdata[31:24]} * {11'h000, LUMA_BLUE};
   assign luma_diff = (luma_a > luma_b) ? (luma_a - luma_b) : (luma_b - luma_a);

   prcd_divider u_div_a (
      .clock    (clock),
      .stage_en (stage_en),
      .num      (front_a.num),
      .den      (front_a.den),
      .quot     (quot_a)
   );

   prcd_divider u_div_b (
      .clock    (clock),
      .stage_en (stage_en),
      .num      (front_b.num),
      .den      (front_b.den),
      .quot     (quot_b)
   );

   // Side data delayed alongside the divider.
   always_ff @(posedge clock) begin
      if (stage_en) begin
         off_a_ff[0]  <= front_a.offset;
         off_b_ff[0]  <= front_b.offset;
         grey_a_ff[0] <= front_a.grey;
         grey_b_ff[0] <= front_b.grey;
         luma_ff[0]   <= luma_diff;
         same_ff[0]   <= (req_tdata[23:0] == req_tdata[47:24]);
         for (int i = 1; i <= DIV_OUT; i++) begin
            off_a_ff[i]  <= off_a_ff[i-1];
            off_b_ff[i]  <= off_b_ff[i-1];
            grey_a_ff[i] <= grey_a_ff[i-1];
            grey_b_ff[i] <= grey_b_ff[i-1];
         end
         for (int i = 1; i < 8; i++) luma_ff[i] <= luma_ff[i-1];
         for (int i = 1; i < 10; i++) same_ff[i] <= same_ff[i-1];
      end
   end

   // Divisor spread delayed to the curve stage.
   always_ff @(posedge clock) begin
      if (stage_en) begin
         den_a_ff[0] <= front_a.den;
         den_b_ff[0] <= front_b.den;
         for (int i = 1; i < DIV_OUT; i++) begin
            den_a_ff[i] <= den_a_ff[i-1];
            den_b_ff[i] <= den_b_ff[i-1];
         end
      end
   end

   // Raw hue from quotient and sector offset; divider output pairs with
   // the side data one stage behind the top of the delay line.
   assign raw_a = grey_a_ff[DIV_OUT-1] ? 8'd0 : (8'(quot_a) + off_a_ff[DIV_OUT-1]);
   assign raw_b = grey_b_ff[DIV_OUT-1] ? 8'd0 : (8'(quot_b) + off_b_ff[DIV_OUT-1]);

   // Circular hue distance, lower saturation and saturation spread.
   always_comb begin
      logic [7:0] g0;
      logic [7:0] g1;
      g0      = hue_a_ff - hue_b_ff;
      g1      = hue_b_ff - hue_a_ff;
      hmin_in = (g0 < g1) ? g0 : g1;
      if (sat_a_ff < sat_b_ff) begin
         smin_in  = sat_a_ff;
         sdiff_in = sat_b_ff - sat_a_ff;
      end else begin
         smin_in  = sat_b_ff;
         sdiff_in = sat_a_ff - sat_b_ff;
      end
   end

   assign lum_prod = {9'h000, luma_ff[7]} * {16'h0000, lum_w_ff};
   assign hue_prod = {9'h000, hprod_ff} * {16'h0000, hue_w_ff};
   assign sum      = 20'(hue_term_ff) + 20'(sat_term2_ff) + 20'(lum_term2_ff);

   // Curve, distance, product and summing stages.
   always_ff @(posedge clock) begin
      if (stage_en) begin
         hue_a_ff     <= hue_curve(raw_a);
         hue_b_ff     <= hue_curve(raw_b);
         sat_a_ff     <= sat_curve(den_a_ff[DIV_OUT-1]);
         sat_b_ff     <= sat_curve(den_b_ff[DIV_OUT-1]);
         hmin_ff      <= hmin_in;
         smin_ff      <= smin_in;
         sdiff_ff     <= sdiff_in;
         hprod_ff     <= {8'h00, hmin_ff} * {8'h00, smin_ff};
         sat_term_ff  <= {9'h000, sdiff_ff} * {8'h00, sat_w_ff};
         lum_term_ff  <= lum_prod[24:8];
         hue_term_ff  <= hue_prod[24:7];
         sat_term2_ff <= sat_term_ff;
         lum_term2_ff <= lum_term_ff;
         diff_ff      <= same_ff[9] ? 13'd0 : sum[18:6];
      end
   end

   // A stalled pipeline keeps every transaction where it is.
   assert property (@(posedge clock) disable iff (reset)
      !stage_en |=> $stable(valid_ff))
      else $error("pipeline moved during a stall");

   // Reset leaves the pipeline empty.
   assert property (@(posedge clock)
      $past(reset) |-> (valid_ff == '0))
      else $error("valid bits survived reset");

   // A non-grey sector quotient of color a never exceeds the wide sector scale.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[DIV_OUT-1] && !grey_a_ff[DIV_OUT-1]) |-> (quot_a <= QUOT_WIDTH'(SCALE_WIDE)))
      else $error("hue quotient out of range");

endmodule

@@ rtl/prcd_divider.sv @@
// ----------------------------------------------------------------------------
// prcd_divider: pipelined restoring divider
// Resolves one quotient bit per stage; the numerator is known to be below
// the divisor times two to the quotient width when the divisor is nonzero.
// ----------------------------------------------------------------------------
module prcd_divider
   import prcd_pkg::*;
(
   input  logic                  clock,
   input  logic                  stage_en,
   input  logic [NUM_WIDTH-1:0]  num,
   input  logic [7:0]            den,
   output logic [QUOT_WIDTH-1:0] quot
);

   logic [NUM_WIDTH-1:0]  rem_ff  [QUOT_WIDTH];
   logic [NUM_WIDTH-1:0]  rem_in  [QUOT_WIDTH];
   logic [7:0]            den_ff  [QUOT_WIDTH];
   logic [QUOT_WIDTH-1:0] quot_ff [QUOT_WIDTH];
   logic [QUOT_WIDTH-1:0] quot_in [QUOT_WIDTH];

   // One trial subtraction per stage, highest quotient bit first.
   always_comb begin
      logic [NUM_WIDTH-1:0]  rem_prev;
      logic [QUOT_WIDTH-1:0] quot_prev;
      logic [7:0]            den_cur;
      logic [NUM_WIDTH-1:0]  trial;
      for (int i = 0; i < QUOT_WIDTH; i++) begin
         rem_prev  = (i == 0) ? num : rem_ff[(i == 0) ? 0 : i - 1];
         quot_prev = (i == 0) ? '0 : quot_ff[(i == 0) ? 0 : i - 1];
         den_cur   = (i == 0) ? den : den_ff[(i == 0) ? 0 : i - 1];
         trial     = NUM_WIDTH'({{(NUM_WIDTH-8){1'b0}}, den_cur} << (QUOT_WIDTH - 1 - i));
         if (rem_prev >= trial) begin
            rem_in[i]  = rem_prev - trial;
            quot_in[i] = quot_prev | QUOT_WIDTH'(1 << (QUOT_WIDTH - 1 - i));
         end else begin
            rem_in[i]  = rem_prev;
            quot_in[i] = quot_prev;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         for (int i = 0; i < QUOT_WIDTH; i++) begin
            rem_ff[i]  <= rem_in[i];
            quot_ff[i] <= quot_in[i];
            den_ff[i]  <= (i == 0) ? den : den_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   assign quot = quot_ff[QUOT_WIDTH-1];

endmodule
